@@ rtl/iea_pkg.sv @@
// Shared types and constants for the indexed effective address unit.
`timescale 1ns / 1ps

package iea_pkg;

    localparam int unsigned IEA_FIFO_DEPTH = 2;
    localparam logic        IEA_CPU_LEVEL_RESET = 1'b1;

    // Result kinds on the output channel.
    typedef enum logic [1:0] {
        KIND_FINAL = 2'd0,
        KIND_READ  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // Work classes handed from the decode side to the execute side.
    typedef enum logic [1:0] {
        OP_FINAL = 2'd0,
        OP_READ  = 2'd1,
        OP_DATA  = 2'd2
    } t_op;

    // Base displacement and outer displacement / indirection size codes.
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_LONG = 2'd3;
    localparam logic [1:0] OD_NONE = 2'd0;

    typedef struct packed {
        t_op         op;
        logic [31:0] base_eff;   // base plus base displacement, or read data
        logic [31:0] idx_eff;    // scaled, possibly suppressed index
        logic [31:0] outer;      // outer displacement
        logic        post;       // post-indexed indirection
        logic [3:0]  bytes;      // displacement bytes consumed
    } t_entry;

endpackage

@@ rtl/iea_front.sv @@
// Decode stage: takes requests, decodes the extension word, forms the base sum.
`timescale 1ns / 1ps

module iea_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_action,
    input  logic [31:0]     i_base_value,
    input  logic [15:0]     i_ext_word,
    input  logic [31:0]     i_index_value,
    input  logic [31:0]     i_base_disp,
    input  logic [31:0]     i_outer_disp,
    input  logic [31:0]     i_read_data,
    output iea_pkg::t_entry o_entry
);
    import iea_pkg::*;

    logic        r_cpu_level;
    logic [31:0] idx_word;
    logic [31:0] idx_scaled;
    logic [31:0] base_sel;
    logic [31:0] bd_val;
    logic [31:0] od_val;
    logic [3:0]  bd_bytes;
    logic [3:0]  od_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_level <= IEA_CPU_LEVEL_RESET;
        end else if (i_cfg_we) begin
            r_cpu_level <= i_cfg_wdata;
        end
    end

    always_comb begin
        idx_word   = i_ext_word[11] ? i_index_value
                                    : {{16{i_index_value[15]}}, i_index_value[15:0]};
        idx_scaled = r_cpu_level ? (idx_word << i_ext_word[10:9]) : idx_word;

        base_sel = i_ext_word[7] ? 32'd0 : i_base_value;

        case (i_ext_word[5:4])
            SZ_WORD: begin
                bd_val   = {{16{i_base_disp[15]}}, i_base_disp[15:0]};
                bd_bytes = 4'd2;
            end
            SZ_LONG: begin
                bd_val   = i_base_disp;
                bd_bytes = 4'd4;
            end
            default: begin
                bd_val   = 32'd0;
                bd_bytes = 4'd0;
            end
        endcase

        case (i_ext_word[1:0])
            SZ_WORD: begin
                od_val   = {{16{i_outer_disp[15]}}, i_outer_disp[15:0]};
                od_bytes = 4'd2;
            end
            SZ_LONG: begin
                od_val   = i_outer_disp;
                od_bytes = 4'd4;
            end
            default: begin
                od_val   = 32'd0;
                od_bytes = 4'd0;
            end
        endcase

        o_entry.outer = od_val;
        o_entry.post  = i_ext_word[2];

        if (i_action) begin
            o_entry.op       = OP_DATA;
            o_entry.base_eff = i_read_data;
            o_entry.idx_eff  = 32'd0;
            o_entry.bytes    = 4'd0;
        end else if (!r_cpu_level || !i_ext_word[8]) begin
            // Brief format: signed byte displacement, no byte count.
            o_entry.op       = OP_FINAL;
            o_entry.base_eff = i_base_value + {{24{i_ext_word[7]}}, i_ext_word[7:0]};
            o_entry.idx_eff  = idx_scaled;
            o_entry.bytes    = 4'd0;
        end else begin
            o_entry.op       = (i_ext_word[1:0] == OD_NONE) ? OP_FINAL : OP_READ;
            o_entry.base_eff = base_sel + bd_val;
            o_entry.idx_eff  = i_ext_word[6] ? 32'd0 : idx_scaled;
            o_entry.bytes    = bd_bytes + od_bytes;
        end
    end

endmodule

@@ rtl/iea_fifo.sv @@
// Short queue of decoded requests between decode and execute.
`timescale 1ns / 1ps

module iea_fifo #(
    parameter int unsigned DEPTH = iea_pkg::IEA_FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  iea_pkg::t_entry i_wdata,
    input  logic            i_pop,
    output iea_pkg::t_entry o_rdata,
    output logic            o_empty,
    output logic            o_full
);
    import iea_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");

endmodule

@@ rtl/iea_back.sv @@
// Execute stage: indirection state, final adds and the result register.
`timescale 1ns / 1ps

module iea_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  iea_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [1:0]      o_kind,
    output logic [31:0]     o_address,
    output logic [3:0]      o_ext_bytes
);
    import iea_pkg::*;

    logic        r_wait;
    logic [31:0] r_held_sum;
    logic [3:0]  r_held_bytes;
    logic        r_out_valid;
    t_kind       r_kind;
    logic [31:0] r_addr;
    logic [3:0]  r_bytes;

    logic        n_wait;
    logic [31:0] n_held_sum;
    logic [3:0]  n_held_bytes;
    t_kind       n_kind;
    logic [31:0] n_addr;
    logic [3:0]  n_bytes;

    assign o_pop       = !i_empty && (!r_out_valid || !i_stall);
    assign o_valid     = r_out_valid;
    assign o_kind      = r_kind;
    assign o_address   = r_addr;
    assign o_ext_bytes = r_bytes;

    always_comb begin
        n_wait       = r_wait;
        n_held_sum   = r_held_sum;
        n_held_bytes = r_held_bytes;
        n_kind       = KIND_FINAL;
        n_addr       = i_entry.base_eff + i_entry.idx_eff;
        n_bytes      = i_entry.bytes;
        case (i_entry.op)
            OP_DATA: begin
                if (r_wait) begin
                    n_wait  = 1'b0;
                    n_addr  = i_entry.base_eff + r_held_sum;
                    n_bytes = r_held_bytes;
                end else begin
                    n_kind  = KIND_ERROR;
                    n_addr  = 32'd0;
                    n_bytes = 4'd0;
                end
            end
            OP_READ: begin
                n_wait       = 1'b1;
                n_kind       = KIND_READ;
                n_addr       = i_entry.base_eff + (i_entry.post ? 32'd0 : i_entry.idx_eff);
                n_held_sum   = (i_entry.post ? i_entry.idx_eff : 32'd0) + i_entry.outer;
                n_held_bytes = i_entry.bytes;
            end
            default: begin
                n_wait = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_wait      <= n_wait;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_held_sum   <= n_held_sum;
            r_held_bytes <= n_held_bytes;
            r_kind       <= n_kind;
            r_addr       <= n_addr;
            r_bytes      <= n_bytes;
        end
    end

    a_error_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_ERROR) |-> (r_addr == 32'd0 && r_bytes == 4'd0))
        else $error("error result carries address or byte count");

    a_read_arms_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.op == OP_READ) |=> (r_wait && r_kind == KIND_READ))
        else $error("read request did not arm the indirection wait");

    a_stray_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.op == OP_DATA && !r_wait) |=> (r_kind == KIND_ERROR && !r_wait))
        else $error("data without a pending read not flagged");

    a_data_clears_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.op == OP_DATA && r_wait) |=> (!r_wait && r_kind == KIND_FINAL))
        else $error("data return did not finish the indirection");

endmodule

@@ rtl/indexed_effective_address_unit_top.sv @@
// Top level of the indexed effective address unit (brief and full extension words).
//
//  Channel   Dir  Handshake            Payload
//  -------   ---  -------------------  ------------------------------------------------
//  request   in   i_valid / o_stall    i_action, i_base_value, i_ext_word, i_index_value,
//                                      i_base_disp, i_outer_disp, i_read_data
//  result    out  o_valid / i_stall    o_kind, o_address, o_ext_bytes
//  config    in   i_cfg_we             i_cfg_wdata (cpu_level)
//
// One request per cycle is sustained while the result side does not stall; a taken request
// is decoded into the queue at the accepting edge, then executed from the queue into the
// result register.
// Throughput is set by the execute stage, which retires one queued request per cycle unless stalled.
// Reset clears the queue, the indirection wait flag and the result valid, and sets
// cpu_level to full addressing; no clearing pass is needed.
// A stall on the result side holds the result register; the queue then absorbs requests
// until full, and only then is o_stall raised toward the requester.
`timescale 1ns / 1ps

module indexed_effective_address_unit_top #(
    parameter int unsigned FIFO_DEPTH = iea_pkg::IEA_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [31:0] i_base_value,
    input  logic [15:0] i_ext_word,
    input  logic [31:0] i_index_value,
    input  logic [31:0] i_base_disp,
    input  logic [31:0] i_outer_disp,
    input  logic [31:0] i_read_data,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_address,
    output logic [3:0]  o_ext_bytes
);
    import iea_pkg::*;

    t_entry dec_entry;
    t_entry q_entry;
    logic   q_push;
    logic   q_pop;
    logic   q_empty;
    logic   q_full;

    // Stall requests only when the queue has no room left.
    assign o_stall = q_full;
    assign q_push  = i_valid && !q_full;

    // Decode: index sign-extension and scaling, suppression, displacement sizing,
    // base plus base displacement.
    iea_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_action      (i_action),
        .i_base_value  (i_base_value),
        .i_ext_word    (i_ext_word),
        .i_index_value (i_index_value),
        .i_base_disp   (i_base_disp),
        .i_outer_disp  (i_outer_disp),
        .i_read_data   (i_read_data),
        .o_entry       (dec_entry)
    );

    // Decouple decode from execute so each side can stall on its own.
    iea_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (dec_entry),
        .i_pop   (q_pop),
        .o_rdata (q_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Execute: hold indirection state across the read, add index and displacements,
    // drive the result register.
    iea_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (q_entry),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_address   (o_address),
        .o_ext_bytes (o_ext_bytes)
    );

endmodule

@@ tb/sv/tb_iea_pkg.sv @@
// Stimulus and prediction codes shared by the address unit testbench files.
`timescale 1ns / 1ps

package tb_iea_pkg;

    // Request action codes.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // cpu_level settings.
    localparam logic LEVEL_BRIEF = 1'b0;
    localparam logic LEVEL_FULL  = 1'b1;

    // Extension word control bits.
    localparam logic [15:0] EXT_LONG_INDEX     = 16'h0800;
    localparam logic [15:0] EXT_FULL           = 16'h0100;
    localparam logic [15:0] EXT_BASE_SUPPRESS  = 16'h0080;
    localparam logic [15:0] EXT_INDEX_SUPPRESS = 16'h0040;
    localparam logic [15:0] EXT_POST_INDEX     = 16'h0004;

endpackage

@@ tb/sv/tb_iea_address_checker.sv @@
// Address predictor and result comparator watching the address unit channels.
`timescale 1ns / 1ps

module tb_iea_address_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic        i_action,
    input  logic [31:0] i_base_value,
    input  logic [15:0] i_ext_word,
    input  logic [31:0] i_index_value,
    input  logic [31:0] i_base_disp,
    input  logic [31:0] i_outer_disp,
    input  logic [31:0] i_read_data,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_address,
    input  logic [3:0]  i_ext_bytes,
    output int          o_mismatches,
    output int          o_pending
);

    import iea_pkg::*;
    import tb_iea_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] address;
        logic [3:0]  ext_bytes;
    } t_ea_result;

    t_ea_result  pending_results[$];

    logic        level;
    logic        awaiting_pointer;
    logic [31:0] saved_outer;
    logic [31:0] saved_post_index;
    logic [3:0]  saved_bytes;

    function automatic logic [31:0] sext16(input logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    function automatic t_ea_result compute_ea(input logic act, input logic [31:0] base_in,
                                              input logic [15:0] ext, input logic [31:0] index_in,
                                              input logic [31:0] bd, input logic [31:0] od,
                                              input logic [31:0] data);
        logic [31:0] base;
        logic [31:0] idx;
        logic [31:0] outer;
        logic [3:0]  bytes;
        t_ea_result  res;
        base  = base_in;
        outer = '0;
        bytes = '0;
        if (act == ACT_DATA) begin
            if (!awaiting_pointer) begin
                res = '{kind: KIND_ERROR, address: '0, ext_bytes: '0};
            end else begin
                awaiting_pointer = 1'b0;
                res = '{kind: KIND_FINAL, address: data + saved_post_index + saved_outer,
                        ext_bytes: saved_bytes};
            end
            return res;
        end
        // A new start abandons any pending indirection.
        awaiting_pointer = 1'b0;
        idx = ((ext & EXT_LONG_INDEX) != 0) ? index_in : sext16(index_in);
        if (level == LEVEL_BRIEF)
            return '{kind: KIND_FINAL, address: base + {{24{ext[7]}}, ext[7:0]} + idx,
                     ext_bytes: '0};
        idx = idx << ext[10:9];
        if ((ext & EXT_FULL) == 0)
            return '{kind: KIND_FINAL, address: base + {{24{ext[7]}}, ext[7:0]} + idx,
                     ext_bytes: '0};
        if ((ext & EXT_BASE_SUPPRESS) != 0)
            base = '0;
        if ((ext & EXT_INDEX_SUPPRESS) != 0)
            idx = '0;
        if (ext[5:4] == SZ_WORD) begin
            base  = base + sext16(bd);
            bytes = bytes + 4'd2;
        end else if (ext[5:4] == SZ_LONG) begin
            base  = base + bd;
            bytes = bytes + 4'd4;
        end
        if (ext[1:0] == SZ_WORD) begin
            outer = sext16(od);
            bytes = bytes + 4'd2;
        end else if (ext[1:0] == SZ_LONG) begin
            outer = od;
            bytes = bytes + 4'd4;
        end
        if (ext[1:0] == OD_NONE)
            return '{kind: KIND_FINAL, address: base + idx, ext_bytes: bytes};
        if ((ext & EXT_POST_INDEX) == 0) begin
            base             = base + idx;
            saved_post_index = '0;
        end else begin
            saved_post_index = idx;
        end
        saved_outer      = outer;
        saved_bytes      = bytes;
        awaiting_pointer = 1'b1;
        return '{kind: KIND_READ, address: base, ext_bytes: bytes};
    endfunction

    // Retire the result before taking the request of the same edge.
    always @(posedge i_clk) begin : watch
        t_ea_result want;
        t_ea_result got;
        if (!i_rst_n) begin
            pending_results.delete();
            o_mismatches     = 0;
            level            = IEA_CPU_LEVEL_RESET;
            awaiting_pointer = 1'b0;
            saved_outer      = '0;
            saved_post_index = '0;
            saved_bytes      = '0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                got = '{kind: t_kind'(i_kind), address: i_address, ext_bytes: i_ext_bytes};
                if (pending_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT)
                        $display("unexpected result: kind %0d address %h ext_bytes %0d",
                                 got.kind, got.address, got.ext_bytes);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.address !== want.address ||
                        got.ext_bytes !== want.ext_bytes) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_LIMIT)
                            $display("mismatch: expected %0d %h %0d, got %0d %h %0d",
                                     want.kind, want.address, want.ext_bytes,
                                     got.kind, got.address, got.ext_bytes);
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                pending_results.push_back(compute_ea(i_action, i_base_value, i_ext_word,
                                                     i_index_value, i_base_disp,
                                                     i_outer_disp, i_read_data));
            if (i_cfg_we)
                level = i_cfg_wdata;
        end
        o_pending = pending_results.size();
    end

endmodule

@@ tb/sv/tb_indexed_effective_address_unit_top.sv @@
// Stimulus, flow control and verdict for the indexed effective address unit.
`timescale 1ns / 1ps

module tb_indexed_effective_address_unit_top;

    import iea_pkg::*;
    import tb_iea_pkg::*;

    localparam int LIMIT_CYCLES   = 400000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLDOFF_CYCLES = 120;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        i_valid       = 1'b0;
    logic        i_action      = 1'b0;
    logic [31:0] i_base_value  = '0;
    logic [15:0] i_ext_word    = '0;
    logic [31:0] i_index_value = '0;
    logic [31:0] i_base_disp   = '0;
    logic [31:0] i_outer_disp  = '0;
    logic [31:0] i_read_data   = '0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [31:0] o_address;
    logic [3:0]  o_ext_bytes;

    int          mismatches;
    int          pending;

    // Idle percentages per side; written by the stimulus with nonblocking assignments.
    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 0;
    // Hold-off handshake between the stimulus and the stall process.
    int          holdoff_asks      = 0;
    int          holdoff_taken     = 0;
    int          holdoff_left      = 0;

    int          cycle_count       = 0;
    int          requests_sent     = 0;
    logic        cpu_level_now     = IEA_CPU_LEVEL_RESET;

    indexed_effective_address_unit_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_base_value (i_base_value),
        .i_ext_word   (i_ext_word),
        .i_index_value(i_index_value),
        .i_base_disp  (i_base_disp),
        .i_outer_disp (i_outer_disp),
        .i_read_data  (i_read_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_address    (o_address),
        .o_ext_bytes  (o_ext_bytes)
    );

    tb_iea_address_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_action     (i_action),
        .i_base_value (i_base_value),
        .i_ext_word   (i_ext_word),
        .i_index_value(i_index_value),
        .i_base_disp  (i_base_disp),
        .i_outer_disp (i_outer_disp),
        .i_read_data  (i_read_data),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_kind       (o_kind),
        .i_address    (o_address),
        .i_ext_bytes  (o_ext_bytes),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort the run if it goes far past the slowest legal schedule.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Drive the result-side stall: a counted hold-off when asked, else random idling.
    initial begin
        forever begin
            @(posedge i_clk);
            if (holdoff_left > 0) begin
                i_stall <= 1'b1;
                holdoff_left--;
            end else if (holdoff_taken != holdoff_asks) begin
                holdoff_taken = holdoff_asks;
                holdoff_left  = HOLDOFF_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < receiver_idle_pct);
            end
        end
    end

    // Mostly random words, with the all-zero and all-one extremes mixed in.
    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return $urandom;
    endfunction

    // Offer one request after a random gap and hold it until it is taken.
    // Entered and left at a rising edge.
    task automatic send_request(input logic act, input logic [31:0] base,
                                input logic [15:0] ext, input logic [31:0] idx,
                                input logic [31:0] bd, input logic [31:0] od,
                                input logic [31:0] data);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_base_value  <= base;
        i_ext_word    <= ext;
        i_index_value <= idx;
        i_base_disp   <= bd;
        i_outer_disp  <= od;
        i_read_data   <= data;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic send_start(input logic [31:0] base, input logic [15:0] ext,
                              input logic [31:0] idx, input logic [31:0] bd,
                              input logic [31:0] od);
        send_request(ACT_START, base, ext, idx, bd, od, rand_word());
    endtask

    // Return pointer data; the calculation fields carry noise.
    task automatic send_data(input logic [31:0] data);
        send_request(ACT_DATA, rand_word(), 16'($urandom), rand_word(), rand_word(),
                     rand_word(), data);
    endtask

    // Wait until every predicted result has come out, then let the pipe settle.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write cpu_level only with the unit empty.
    task automatic set_level(input logic lvl);
        i_valid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lvl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cpu_level_now = lvl;
    endtask

    function automatic logic starts_indirection(input logic [15:0] ext);
        return cpu_level_now == LEVEL_FULL && (ext & EXT_FULL) != 0 && ext[1:0] != OD_NONE;
    endfunction

    // Random traffic: mostly full-format starts, indirections usually followed by their
    // data, plus stray data returns and abandoned indirections as noise.
    task automatic run_random(input int count);
        int          stop_at;
        int          pick;
        logic [15:0] ext;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            pick = $urandom_range(99);
            ext  = 16'($urandom);
            if (pick < 10) begin
                send_data(rand_word());
            end else begin
                if (pick < 80)
                    ext = ext | EXT_FULL;
                if (pick < 60 && ext[1:0] == OD_NONE)
                    ext[1:0] = 2'($urandom_range(3, 1));
                send_start(rand_word(), ext, rand_word(), rand_word(), rand_word());
                if (starts_indirection(ext) && $urandom_range(99) < 85)
                    send_data(rand_word());
            end
        end
    endtask

    initial begin
        // Hold reset, then release it at an edge.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct   <= 28;
        receiver_idle_pct <= 52;
        set_level(LEVEL_FULL);

        // Brief format: signed 8-bit displacement, word and long index, index scaling.
        send_start(32'h0000_1000, 16'h007F, 32'h0000_8001, '0, '0);
        send_start(32'hFFFF_FFFF, 16'h0880, 32'hFFFF_FFFF, '0, '0);
        send_start(32'h0000_0000, 16'h0E10, 32'h1234_5678, '0, '0);
        // Full format without indirection: each base displacement size.
        send_start(32'h8000_0000, 16'h0130, 32'h0000_0010, 32'hFFFF_FFFF, '0);
        send_start(32'h0000_4000, 16'h0120, 32'h0000_7FFF, 32'h0000_8000, '0);
        send_start(32'h0000_4000, 16'h0110, 32'h0000_0004, 32'hDEAD_BEEF, '0);
        // Reserved base size behaves as a null displacement.
        send_start(32'h0000_4000, 16'h0100, 32'h0000_0004, 32'hDEAD_BEEF, '0);
        // Base and index both suppressed.
        send_start(32'hFFFF_FFFF, 16'h01F0, 32'hFFFF_FFFF, 32'h0000_0000, '0);
        // Post-index bit with no indirection adds the index as usual.
        send_start(32'h0000_2000, 16'h0B24, 32'h0000_0100, 32'h0000_FFF0, '0);
        // Pre-indexed indirection, null then word outer displacement.
        send_start(32'h0001_0000, 16'h0131, 32'h0000_0008, 32'h0000_0100, '0);
        send_data(32'h0002_0000);
        send_start(32'h0001_0000, 16'h0122, 32'h0000_0008, 32'h0000_0100, 32'h0000_FFFE);
        send_data(32'h0003_0000);
        // Post-indexed indirection with long outer displacement.
        send_start(32'h0001_0000, 16'h0B37, 32'h0000_0003, 32'h1000_0000, 32'h7FFF_FFFF);
        send_data(32'hFFFF_FFFF);
        // Data with no read request outstanding.
        send_data(32'h5555_AAAA);
        // Start while waiting abandons the indirection; the data then has no owner.
        send_start(32'h0000_0000, 16'h01C7, 32'h0000_0040, '0, 32'h0000_0002);
        send_start(32'h0000_0100, 16'h0000, 32'h0000_0001, '0, '0);
        send_data(32'h0000_1111);
        send_start(32'h0000_0100, 16'h0570, 32'h0000_0001, 32'h0000_0020, '0);

        // Brief-only level: full bit and scale ignored, no displacement bytes.
        set_level(LEVEL_BRIEF);
        send_start(32'h0000_1000, 16'h0F37, 32'h8000_0001, '0, '0);
        send_start(32'hFFFF_FFFF, 16'h01FF, 32'hFFFF_7FFF, '0, '0);
        send_data(32'hFFFF_FFFF);
        run_random(300);

        // Back to full addressing; starve the result side so the queue fills.
        set_level(LEVEL_FULL);
        holdoff_asks <= holdoff_asks + 1;
        run_random(700);

        sender_idle_pct   <= 52;
        receiver_idle_pct <= 28;
        run_random(600);

        sender_idle_pct   <= 0;
        receiver_idle_pct <= 0;
        run_random(400);

        i_valid <= 1'b0;
        wait_drained();
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/iea_pkg.sv
rtl/iea_front.sv
rtl/iea_fifo.sv
rtl/iea_back.sv
rtl/indexed_effective_address_unit_top.sv
tb/sv/tb_iea_pkg.sv
tb/sv/tb_iea_address_checker.sv
tb/sv/tb_indexed_effective_address_unit_top.sv
